>>> rtl/core/order_book_depth_engine_top_macros.svh
// ----------------------------------------------------------------------------
// Order book depth engine assertion macros
// Shared concurrent assertion forms for the depth engine RTL.
// ----------------------------------------------------------------------------
`ifndef ORDER_BOOK_DEPTH_ENGINE_TOP_MACROS_SVH
`define ORDER_BOOK_DEPTH_ENGINE_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define OBDE_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define OBDE_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/obde_pkg.sv
// ----------------------------------------------------------------------------
// Order book depth engine package
// Payload structs, opcodes, sequencer states and shared widths.
// ----------------------------------------------------------------------------
package obde_pkg;

  localparam int PRICE_W   = 32;
  localparam int SIZE_W    = 31;
  localparam int BOOK_W    = 4;
  localparam int POS_W     = 6;
  localparam int LVL_W     = 5;
  localparam int CNT_IDX_W = 5;  // {book, side}
  localparam int CNT_W     = 6;  // holds up to 63 levels
  localparam int ENABLE_W  = 16;

  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_UPDATE = 2'd1,
    REQ_DELETE = 2'd2,
    REQ_CLEAR  = 2'd3
  } req_type_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOAD_BID,
    S_LOAD_ASK,
    S_DECIDE,
    S_MOVE_RD,
    S_MOVE_WR,
    S_PUT,
    S_WB_BID,
    S_WB_ASK,
    S_SNAP
  } state_e;

  typedef struct packed {
    req_type_e           req_type;
    logic [BOOK_W-1:0]   book_id;
    logic                side;
    logic [POS_W-1:0]    position;
    logic [PRICE_W-1:0]  price;
    logic [SIZE_W-1:0]   size;
  } req_t;

  typedef struct packed {
    logic [BOOK_W-1:0]   out_book;
    logic                out_side;
    logic [LVL_W-1:0]    level;
    logic                occupied;
    logic [PRICE_W-1:0]  level_price;
    logic [SIZE_W-1:0]   level_size;
    logic                last_of_run;
  } rsp_t;

  typedef struct packed {
    logic                 we;
    logic [CNT_IDX_W-1:0] idx;
    logic [CNT_W-1:0]     data;
  } cnt_wr_t;

endpackage

>>> rtl/core/obde_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module obde_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/obde_cnt_tbl.sv
// ----------------------------------------------------------------------------
// Level count table
// One level count per book side, cleared at reset, one read and one write.
// ----------------------------------------------------------------------------
module obde_cnt_tbl #(
  parameter int DEPTH = 32
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic [obde_pkg::CNT_IDX_W-1:0]   rd_idx_i,
  output logic [obde_pkg::CNT_W-1:0]       rd_cnt_o,
  input  obde_pkg::cnt_wr_t                wr_i
);

  import obde_pkg::*;

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [CNT_W-1:0] cnt_q [DEPTH];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DEPTH; i++) begin
        cnt_q[i] <= '0;
      end
    end else if (wr_i.we) begin
      cnt_q[wr_i.idx[IW-1:0]] <= wr_i.data;
    end
  end

  assign rd_cnt_o = cnt_q[rd_idx_i[IW-1:0]];

endmodule

>>> rtl/core/order_book_depth_engine_top.sv
// ----------------------------------------------------------------------------
// Order book depth engine
// Positional bid/ask level keeper for several books with full-side snapshots.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: an item is a transfer at a rising edge with start_i high
//   and busy_o low. req_i names the book, side, position and operation.
//   Result channel: rsp_strobe_o marks each snapshot slot for exactly one
//   cycle; the receiver cannot hold results off. Bid slots come first, then
//   ask slots, 2*LEVELS_PER_SIDE results in all, last_of_run on the final one.
//   Config channel: cfg_data_i loads the book enable mask when cfg_valid_i and
//   cfg_ready_o are both high; ready is high whenever the sequencer is idle.
// Timing:
//   The bid count loads, then the ask count, then the decide state runs. An
//   insert or delete then shifts levels with a read and a write back per
//   moved level, and an insert before the tail then writes the new level.
//   The bid and ask counts are written back and the snapshot reads one slot
//   per cycle, each result following in the cycle after its read. A clear
//   only loads, decides and writes the counts back, and an ignored item
//   never raises busy_o; neither gives results.
// Reset:
//   All level counts and the enable mask clear, so every book is empty and
//   disabled. Level RAM contents are not cleared; empty slots read as zero.
// ----------------------------------------------------------------------------
`include "order_book_depth_engine_top_macros.svh"

module order_book_depth_engine_top #(
  parameter int LEVELS_PER_SIDE = 10,
  parameter int NUM_BOOKS       = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  output logic                           busy_o,
  input  obde_pkg::req_t                 req_i,
  output logic                           rsp_strobe_o,
  output obde_pkg::rsp_t                 rsp_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [obde_pkg::ENABLE_W-1:0]  cfg_data_i
);

  import obde_pkg::*;

  localparam int NS = 2 * NUM_BOOKS * LEVELS_PER_SIDE;
  localparam int AW = $clog2(NS);
  localparam int LW = $clog2(LEVELS_PER_SIDE + 1);
  localparam int DW = PRICE_W + SIZE_W;

  // Flat slot address: (book*2 + side)*LEVELS_PER_SIDE + level.
  function automatic logic [AW-1:0] slot_addr(logic [BOOK_W-1:0] book, logic sd,
                                               logic [LW-1:0] k);
    logic [15:0] t;
    t = (16'(book) * 16'd2 + 16'(sd)) * 16'(LEVELS_PER_SIDE) + 16'(k);
    return t[AW-1:0];
  endfunction

  state_e               state_q, state_d;
  req_t                 req_q;
  logic [ENABLE_W-1:0]  enable_q;
  logic [LW-1:0]        cnt_bid_q, cnt_bid_d;
  logic [LW-1:0]        cnt_ask_q, cnt_ask_d;
  logic [LW-1:0]        cur_q, cur_d;
  logic [LW-1:0]        lim_q, lim_d;
  logic                 snap_side_q, snap_side_d;
  logic [LW-1:0]        snap_lvl_q, snap_lvl_d;
  logic                 rsp_vld_q, rsp_vld_d;
  logic                 rsp_side_q, rsp_side_d;
  logic [LW-1:0]        rsp_lvl_q, rsp_lvl_d;
  logic                 rsp_occ_q, rsp_occ_d;
  logic                 rsp_last_q, rsp_last_d;

  logic                 accept;
  logic                 book_ok;
  logic [CNT_IDX_W-1:0] cnt_rd_idx;
  logic [CNT_W-1:0]     cnt_rd;
  cnt_wr_t              cnt_wr;
  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [DW-1:0]        ram_wdata;
  logic [AW-1:0]        ram_raddr;
  logic [DW-1:0]        ram_rdata;

  logic [LW-1:0]        side_cnt;
  logic [LW-1:0]        new_cnt;
  logic                 pos_lt_cnt;
  logic                 side_full;
  logic [LW-1:0]        pos_lw;
  logic [LW-1:0]        ins_top;
  logic [LW:0]          del_next;
  logic [LW-1:0]        snap_cnt;
  logic [DW-1:0]        new_entry;

  assign accept      = start_i && !busy_o;
  assign busy_o      = (state_q != S_IDLE);
  assign cfg_ready_o = (state_q == S_IDLE);
  assign book_ok     = ({1'b0, req_i.book_id} < 5'(NUM_BOOKS)) && enable_q[req_i.book_id];

  assign side_cnt   = req_q.side ? cnt_bid_q : cnt_ask_q;
  assign pos_lt_cnt = {1'b0, req_q.position} < 7'(side_cnt);
  assign side_full  = (side_cnt == LW'(LEVELS_PER_SIDE));
  assign pos_lw     = LW'(req_q.position);
  assign ins_top    = side_full ? LW'(LEVELS_PER_SIDE - 1) : side_cnt;
  assign del_next   = {1'b0, cur_q} + (LW+1)'(2);
  assign snap_cnt   = snap_side_q ? cnt_bid_q : cnt_ask_q;
  assign new_entry  = {req_q.price, req_q.size};

  // Enable mask.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      enable_q <= cfg_data_i;
    end
  end

  // Hold the accepted request.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= req_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_bid_q   <= '0;
      cnt_ask_q   <= '0;
      cur_q       <= '0;
      lim_q       <= '0;
      snap_side_q <= 1'b0;
      snap_lvl_q  <= '0;
      rsp_vld_q   <= 1'b0;
      rsp_side_q  <= 1'b0;
      rsp_lvl_q   <= '0;
      rsp_occ_q   <= 1'b0;
      rsp_last_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_bid_q   <= cnt_bid_d;
      cnt_ask_q   <= cnt_ask_d;
      cur_q       <= cur_d;
      lim_q       <= lim_d;
      snap_side_q <= snap_side_d;
      snap_lvl_q  <= snap_lvl_d;
      rsp_vld_q   <= rsp_vld_d;
      rsp_side_q  <= rsp_side_d;
      rsp_lvl_q   <= rsp_lvl_d;
      rsp_occ_q   <= rsp_occ_d;
      rsp_last_q  <= rsp_last_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cnt_bid_d   = cnt_bid_q;
    cnt_ask_d   = cnt_ask_q;
    cur_d       = cur_q;
    lim_d       = lim_q;
    snap_side_d = snap_side_q;
    snap_lvl_d  = snap_lvl_q;
    rsp_vld_d   = 1'b0;
    rsp_side_d  = rsp_side_q;
    rsp_lvl_d   = rsp_lvl_q;
    rsp_occ_d   = rsp_occ_q;
    rsp_last_d  = rsp_last_q;
    new_cnt     = side_cnt;
    cnt_rd_idx  = {req_q.book_id, 1'b1};
    cnt_wr      = '0;
    ram_we      = 1'b0;
    ram_waddr   = slot_addr(req_q.book_id, req_q.side, pos_lw);
    ram_wdata   = new_entry;
    ram_raddr   = slot_addr(req_q.book_id, snap_side_q, snap_lvl_q);

    case (state_q)
      S_IDLE: begin
        // Drop items for out-of-range or disabled books right here.
        if (accept && book_ok) begin
          state_d = S_LOAD_BID;
        end
      end
      S_LOAD_BID: begin
        cnt_rd_idx = {req_q.book_id, 1'b1};
        cnt_bid_d  = LW'(cnt_rd);
        state_d    = S_LOAD_ASK;
      end
      S_LOAD_ASK: begin
        cnt_rd_idx = {req_q.book_id, 1'b0};
        cnt_ask_d  = LW'(cnt_rd);
        state_d    = S_DECIDE;
      end
      S_DECIDE: begin
        state_d = S_WB_BID;
        case (req_q.req_type)
          REQ_CLEAR: begin
            cnt_bid_d = '0;
            cnt_ask_d = '0;
          end
          REQ_INSERT: begin
            if (!pos_lt_cnt) begin
              // Append at the tail unless the side is full.
              if (!side_full) begin
                ram_we    = 1'b1;
                ram_waddr = slot_addr(req_q.book_id, req_q.side, side_cnt);
                new_cnt   = side_cnt + LW'(1);
              end
            end else begin
              if (!side_full) begin
                new_cnt = side_cnt + LW'(1);
              end
              cur_d   = ins_top;
              state_d = (ins_top > pos_lw) ? S_MOVE_RD : S_PUT;
            end
          end
          REQ_UPDATE: begin
            if (pos_lt_cnt) begin
              ram_we = 1'b1;
            end
          end
          REQ_DELETE: begin
            if (pos_lt_cnt) begin
              new_cnt = side_cnt - LW'(1);
              cur_d   = pos_lw;
              lim_d   = side_cnt;
              if (({1'b0, pos_lw} + (LW+1)'(1)) < {1'b0, side_cnt}) begin
                state_d = S_MOVE_RD;
              end
            end
          end
          default: begin
          end
        endcase
        if (req_q.req_type != REQ_CLEAR) begin
          if (req_q.side) begin
            cnt_bid_d = new_cnt;
          end else begin
            cnt_ask_d = new_cnt;
          end
        end
      end
      S_MOVE_RD: begin
        // Fetch the neighbor that moves into cur_q.
        if (req_q.req_type == REQ_INSERT) begin
          ram_raddr = slot_addr(req_q.book_id, req_q.side, cur_q - LW'(1));
        end else begin
          ram_raddr = slot_addr(req_q.book_id, req_q.side, cur_q + LW'(1));
        end
        state_d = S_MOVE_WR;
      end
      S_MOVE_WR: begin
        ram_we    = 1'b1;
        ram_waddr = slot_addr(req_q.book_id, req_q.side, cur_q);
        ram_wdata = ram_rdata;
        if (req_q.req_type == REQ_INSERT) begin
          cur_d   = cur_q - LW'(1);
          state_d = ((cur_q - LW'(1)) > pos_lw) ? S_MOVE_RD : S_PUT;
        end else begin
          cur_d   = cur_q + LW'(1);
          state_d = (del_next < {1'b0, lim_q}) ? S_MOVE_RD : S_WB_BID;
        end
      end
      S_PUT: begin
        ram_we  = 1'b1;
        state_d = S_WB_BID;
      end
      S_WB_BID: begin
        cnt_wr.we   = 1'b1;
        cnt_wr.idx  = {req_q.book_id, 1'b1};
        cnt_wr.data = CNT_W'(cnt_bid_q);
        state_d     = S_WB_ASK;
      end
      S_WB_ASK: begin
        cnt_wr.we   = 1'b1;
        cnt_wr.idx  = {req_q.book_id, 1'b0};
        cnt_wr.data = CNT_W'(cnt_ask_q);
        snap_side_d = 1'b1;
        snap_lvl_d  = '0;
        state_d     = (req_q.req_type == REQ_CLEAR) ? S_IDLE : S_SNAP;
      end
      S_SNAP: begin
        // Issue one slot read per cycle; its result shows next cycle.
        rsp_vld_d  = 1'b1;
        rsp_side_d = snap_side_q;
        rsp_lvl_d  = snap_lvl_q;
        rsp_occ_d  = snap_lvl_q < snap_cnt;
        rsp_last_d = !snap_side_q && (snap_lvl_q == LW'(LEVELS_PER_SIDE - 1));
        if (snap_lvl_q == LW'(LEVELS_PER_SIDE - 1)) begin
          snap_lvl_d = '0;
          if (snap_side_q) begin
            snap_side_d = 1'b0;
          end else begin
            state_d = S_IDLE;
          end
        end else begin
          snap_lvl_d = snap_lvl_q + LW'(1);
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  obde_cnt_tbl #(
    .DEPTH (2 * NUM_BOOKS)
  ) u_cnt_tbl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rd_idx_i (cnt_rd_idx),
    .rd_cnt_o (cnt_rd),
    .wr_i     (cnt_wr)
  );

  obde_ram #(
    .WIDTH (DW),
    .DEPTH (NS)
  ) u_level_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Empty slots report zero price and size.
  assign rsp_strobe_o        = rsp_vld_q;
  assign rsp_o.out_book      = req_q.book_id;
  assign rsp_o.out_side      = rsp_side_q;
  assign rsp_o.level         = LVL_W'(rsp_lvl_q);
  assign rsp_o.occupied      = rsp_occ_q;
  assign rsp_o.level_price   = rsp_occ_q ? ram_rdata[DW-1:SIZE_W] : '0;
  assign rsp_o.level_size    = rsp_occ_q ? ram_rdata[SIZE_W-1:0] : '0;
  assign rsp_o.last_of_run   = rsp_last_q;

  `OBDE_ASSERT_NXT(a_snap_strobe, clk_i, rst_ni, state_q == S_SNAP, rsp_strobe_o,
                   "snapshot read without result strobe")
  `OBDE_ASSERT_IMP(a_last_slot, clk_i, rst_ni, rsp_strobe_o && rsp_o.last_of_run,
                   !rsp_o.out_side && (rsp_lvl_q == LW'(LEVELS_PER_SIDE - 1)),
                   "last_of_run not on the final ask slot")
  `OBDE_ASSERT_IMP(a_ram_wr_state, clk_i, rst_ni, ram_we,
                   state_q == S_DECIDE || state_q == S_MOVE_WR || state_q == S_PUT,
                   "level RAM written outside an update step")
  `OBDE_ASSERT_NXT(a_move_pair, clk_i, rst_ni, state_q == S_MOVE_RD,
                   state_q == S_MOVE_WR, "shift read not followed by write back")

endmodule
